// File: design/qmr_pkg.sv
// Shared types, constants and arithmetic helpers of the quaternion multiply and rotate unit.
package qmr_pkg;

    localparam int DATA_W = 16;
    localparam int FRAC_W = 14;
    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int RND_W  = SUM_W - FRAC_W;
    localparam int ACC_W  = RND_W + 1;

    localparam logic [1:0] FUNC_PROD = 2'd0;
    localparam logic [1:0] FUNC_ROT  = 2'd1;
    localparam logic [1:0] FUNC_CONJ = 2'd2;

    localparam int QW = 0;
    localparam int QX = 1;
    localparam int QY = 2;
    localparam int QZ = 3;

    localparam int VX = 0;
    localparam int VY = 1;
    localparam int VZ = 2;

    localparam logic signed [SUM_W-1:0] SUM_HALF =
        {{(SUM_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ACC_MAX =
        {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = ~ACC_MAX;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [RND_W-1:0]  t_rnd;
    typedef logic signed [ACC_W-1:0]  t_acc;

    typedef struct packed {
        logic [1:0] func;
        t_data      a_w;
        t_data      a_x;
        t_data      a_y;
        t_data      a_z;
        t_data      b_w;
        t_data      b_x;
        t_data      b_y;
        t_data      b_z;
    } t_in_item;

    typedef struct packed {
        t_data r_w;
        t_data r_x;
        t_data r_y;
        t_data r_z;
        logic  saturated;
    } t_out_item;

    typedef struct packed {
        t_data val;
        logic  clip;
    } t_sat;

    typedef struct packed {
        logic                valid;
        logic [1:0]          func;
        t_data [3:0]         a;
        t_data [2:0]         v;
        t_prod [3:0][3:0]    prod;
    } t_stg_a;

    typedef struct packed {
        logic        valid;
        logic [1:0]  func;
        t_data [3:0] a;
        t_data [2:0] v;
        t_data [3:0] res;
        logic        clip;
        t_data [2:0] c;
    } t_stg_b;

    typedef struct packed {
        logic        valid;
        logic [1:0]  func;
        t_data [2:0] v;
        t_data [3:0] res;
        logic        clip;
        t_prod [2:0] wc;
        t_prod [2:0] pos;
        t_prod [2:0] neg;
    } t_stg_c;

    function automatic t_sum ext_prod(input t_prod p);
        return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
    endfunction

    function automatic t_acc ext_data(input t_data d);
        return {{(ACC_W-DATA_W){d[DATA_W-1]}}, d};
    endfunction

    function automatic t_acc ext_rnd(input t_rnd r);
        return {{(ACC_W-RND_W){r[RND_W-1]}}, r};
    endfunction

    // Rounds an exact sum to the data scale, halves rounding toward plus infinity.
    function automatic t_rnd round_sum(input t_sum s);
        t_sum t;
        t = s + SUM_HALF;
        return t[SUM_W-1:FRAC_W];
    endfunction

    function automatic t_sat sat_acc(input t_acc x);
        t_sat r;
        r.clip = 1'b0;
        r.val  = x[DATA_W-1:0];
        if (x > ACC_MAX) begin
            r.val  = ACC_MAX[DATA_W-1:0];
            r.clip = 1'b1;
        end else if (x < ACC_MIN) begin
            r.val  = ACC_MIN[DATA_W-1:0];
            r.clip = 1'b1;
        end
        return r;
    endfunction

endpackage

// File: design/qmr_mul_array.sv
// First pipeline stage: all sixteen products of A's and B's components.
module qmr_mul_array (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  qmr_pkg::t_in_item i_item,
    output qmr_pkg::t_stg_a   o_stg
);

    qmr_pkg::t_stg_a r_stg;
    qmr_pkg::t_stg_a n_stg;
    qmr_pkg::t_data  av [4];
    qmr_pkg::t_data  bv [4];

    always_comb begin
        av[qmr_pkg::QW] = i_item.a_w;
        av[qmr_pkg::QX] = i_item.a_x;
        av[qmr_pkg::QY] = i_item.a_y;
        av[qmr_pkg::QZ] = i_item.a_z;
        bv[qmr_pkg::QW] = i_item.b_w;
        bv[qmr_pkg::QX] = i_item.b_x;
        bv[qmr_pkg::QY] = i_item.b_y;
        bv[qmr_pkg::QZ] = i_item.b_z;
        n_stg.valid = i_valid;
        n_stg.func  = i_item.func;
        n_stg.v[qmr_pkg::VX] = i_item.b_x;
        n_stg.v[qmr_pkg::VY] = i_item.b_y;
        n_stg.v[qmr_pkg::VZ] = i_item.b_z;
        for (int i = 0; i < 4; i++) begin
            n_stg.a[i] = av[i];
            for (int j = 0; j < 4; j++) begin
                n_stg.prod[i][j] = av[i] * bv[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg <= '0;
        end else begin
            r_stg <= n_stg;
        end
    end

    assign o_stg = r_stg;

endmodule

// File: design/qmr_dot_round.sv
// Second pipeline stage: product sums, cross product, conjugate, rounding and saturation.
module qmr_dot_round (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  qmr_pkg::t_stg_a i_stg,
    output qmr_pkg::t_stg_b o_stg
);

    qmr_pkg::t_stg_b r_stg;
    qmr_pkg::t_stg_b n_stg;
    qmr_pkg::t_sum   p [4][4];
    qmr_pkg::t_sum   s_q [4];
    qmr_pkg::t_sum   s_c [3];
    qmr_pkg::t_sat   q_sat [4];
    qmr_pkg::t_sat   c_sat [3];
    qmr_pkg::t_sat   n_sat [3];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                p[i][j] = qmr_pkg::ext_prod(i_stg.prod[i][j]);
            end
        end

        s_q[qmr_pkg::QW] = p[qmr_pkg::QW][qmr_pkg::QW] - p[qmr_pkg::QX][qmr_pkg::QX]
                         - p[qmr_pkg::QY][qmr_pkg::QY] - p[qmr_pkg::QZ][qmr_pkg::QZ];
        s_q[qmr_pkg::QX] = p[qmr_pkg::QW][qmr_pkg::QX] + p[qmr_pkg::QX][qmr_pkg::QW]
                         + p[qmr_pkg::QY][qmr_pkg::QZ] - p[qmr_pkg::QZ][qmr_pkg::QY];
        s_q[qmr_pkg::QY] = p[qmr_pkg::QW][qmr_pkg::QY] - p[qmr_pkg::QX][qmr_pkg::QZ]
                         + p[qmr_pkg::QY][qmr_pkg::QW] + p[qmr_pkg::QZ][qmr_pkg::QX];
        s_q[qmr_pkg::QZ] = p[qmr_pkg::QW][qmr_pkg::QZ] + p[qmr_pkg::QX][qmr_pkg::QY]
                         - p[qmr_pkg::QY][qmr_pkg::QX] + p[qmr_pkg::QZ][qmr_pkg::QW];

        s_c[qmr_pkg::VX] = p[qmr_pkg::QY][qmr_pkg::QZ] - p[qmr_pkg::QZ][qmr_pkg::QY];
        s_c[qmr_pkg::VY] = p[qmr_pkg::QZ][qmr_pkg::QX] - p[qmr_pkg::QX][qmr_pkg::QZ];
        s_c[qmr_pkg::VZ] = p[qmr_pkg::QX][qmr_pkg::QY] - p[qmr_pkg::QY][qmr_pkg::QX];

        for (int i = 0; i < 4; i++) begin
            q_sat[i] = qmr_pkg::sat_acc(qmr_pkg::ext_rnd(qmr_pkg::round_sum(s_q[i])));
        end
        for (int i = 0; i < 3; i++) begin
            c_sat[i] = qmr_pkg::sat_acc(qmr_pkg::ext_rnd(qmr_pkg::round_sum(s_c[i])));
            n_sat[i] = qmr_pkg::sat_acc(-qmr_pkg::ext_data(i_stg.a[i+1]));
        end

        n_stg.valid = i_stg.valid;
        n_stg.func  = i_stg.func;
        n_stg.a     = i_stg.a;
        n_stg.v     = i_stg.v;
        for (int i = 0; i < 3; i++) begin
            n_stg.c[i] = c_sat[i].val;
        end

        case (i_stg.func)
            qmr_pkg::FUNC_PROD: begin
                for (int i = 0; i < 4; i++) begin
                    n_stg.res[i] = q_sat[i].val;
                end
                n_stg.clip = q_sat[0].clip | q_sat[1].clip | q_sat[2].clip | q_sat[3].clip;
            end
            qmr_pkg::FUNC_ROT: begin
                n_stg.res  = '0;
                n_stg.clip = c_sat[0].clip | c_sat[1].clip | c_sat[2].clip;
            end
            qmr_pkg::FUNC_CONJ: begin
                n_stg.res[qmr_pkg::QW] = i_stg.a[qmr_pkg::QW];
                for (int i = 0; i < 3; i++) begin
                    n_stg.res[i+1] = n_sat[i].val;
                end
                n_stg.clip = n_sat[0].clip | n_sat[1].clip | n_sat[2].clip;
            end
            default: begin
                n_stg.res  = '0;
                n_stg.clip = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg <= '0;
        end else begin
            r_stg <= n_stg;
        end
    end

    assign o_stg = r_stg;

endmodule

// File: design/qmr_rot_mul.sv
// Third pipeline stage: products of the cross product with A's scalar and vector parts.
module qmr_rot_mul (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  qmr_pkg::t_stg_b i_stg,
    output qmr_pkg::t_stg_c o_stg
);

    qmr_pkg::t_stg_c r_stg;
    qmr_pkg::t_stg_c n_stg;
    qmr_pkg::t_data  w;
    qmr_pkg::t_data  ux;
    qmr_pkg::t_data  uy;
    qmr_pkg::t_data  uz;
    qmr_pkg::t_data  cx;
    qmr_pkg::t_data  cy;
    qmr_pkg::t_data  cz;

    always_comb begin
        w  = i_stg.a[qmr_pkg::QW];
        ux = i_stg.a[qmr_pkg::QX];
        uy = i_stg.a[qmr_pkg::QY];
        uz = i_stg.a[qmr_pkg::QZ];
        cx = i_stg.c[qmr_pkg::VX];
        cy = i_stg.c[qmr_pkg::VY];
        cz = i_stg.c[qmr_pkg::VZ];

        n_stg.valid = i_stg.valid;
        n_stg.func  = i_stg.func;
        n_stg.v     = i_stg.v;
        n_stg.res   = i_stg.res;
        n_stg.clip  = i_stg.clip;

        n_stg.wc[qmr_pkg::VX]  = w * cx;
        n_stg.wc[qmr_pkg::VY]  = w * cy;
        n_stg.wc[qmr_pkg::VZ]  = w * cz;
        n_stg.pos[qmr_pkg::VX] = uy * cz;
        n_stg.pos[qmr_pkg::VY] = uz * cx;
        n_stg.pos[qmr_pkg::VZ] = ux * cy;
        n_stg.neg[qmr_pkg::VX] = uz * cy;
        n_stg.neg[qmr_pkg::VY] = ux * cz;
        n_stg.neg[qmr_pkg::VZ] = uy * cx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg <= '0;
        end else begin
            r_stg <= n_stg;
        end
    end

    assign o_stg = r_stg;

endmodule

// File: design/qmr_rot_sum.sv
// Fourth pipeline stage: rotation sums, final saturation and the result register.
module qmr_rot_sum (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qmr_pkg::t_stg_c    i_stg,
    output logic               o_valid,
    output qmr_pkg::t_out_item o_result
);

    logic               r_valid;
    qmr_pkg::t_out_item r_result;
    qmr_pkg::t_out_item n_result;
    qmr_pkg::t_sum      s [3];
    qmr_pkg::t_sum      d [3];
    qmr_pkg::t_acc      tot [3];
    qmr_pkg::t_sat      r_sat [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s[i]     = qmr_pkg::ext_prod(i_stg.wc[i]) + qmr_pkg::ext_prod(i_stg.pos[i])
                     - qmr_pkg::ext_prod(i_stg.neg[i]);
            d[i]     = {s[i][qmr_pkg::SUM_W-2:0], 1'b0};
            tot[i]   = qmr_pkg::ext_rnd(qmr_pkg::round_sum(d[i]))
                     + qmr_pkg::ext_data(i_stg.v[i]);
            r_sat[i] = qmr_pkg::sat_acc(tot[i]);
        end

        if (i_stg.func == qmr_pkg::FUNC_ROT) begin
            n_result.r_w       = '0;
            n_result.r_x       = r_sat[qmr_pkg::VX].val;
            n_result.r_y       = r_sat[qmr_pkg::VY].val;
            n_result.r_z       = r_sat[qmr_pkg::VZ].val;
            n_result.saturated = i_stg.clip | r_sat[0].clip | r_sat[1].clip | r_sat[2].clip;
        end else begin
            n_result.r_w       = i_stg.res[qmr_pkg::QW];
            n_result.r_x       = i_stg.res[qmr_pkg::QX];
            n_result.r_y       = i_stg.res[qmr_pkg::QY];
            n_result.r_z       = i_stg.res[qmr_pkg::QZ];
            n_result.saturated = i_stg.clip;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_stg.valid;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: design/quaternion_multiply_rotate_unit.sv
// Top level of the fixed-point quaternion multiply, rotate and conjugate unit.
//
//  Channel   Ports                      Handshake
//  --------  -------------------------  ---------------------------------------
//  item in   i_start, o_busy, i_item    taken at an edge with i_start and !o_busy
//  result    o_valid, o_result          shown for one cycle, taken at its end
//
// Every item passes through the four register stages (multiply, sum and
// round, multiply, sum and saturate) before its result appears. A new item
// can enter at every edge while o_busy is low.
// A synchronous reset empties the pipeline and holds o_busy high until the
// cycle after reset is released. The receiver cannot stall, so nothing waits.
module quaternion_multiply_rotate_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  qmr_pkg::t_in_item  i_item,
    output logic               o_busy,
    output logic               o_valid,
    output qmr_pkg::t_out_item o_result
);

    logic            r_busy;
    qmr_pkg::t_stg_a stg_a;
    qmr_pkg::t_stg_b stg_b;
    qmr_pkg::t_stg_c stg_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign o_busy = r_busy;

    qmr_mul_array u_mul_array (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start & ~r_busy),
        .i_item  (i_item),
        .o_stg   (stg_a)
    );

    qmr_dot_round u_dot_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stg   (stg_a),
        .o_stg   (stg_b)
    );

    qmr_rot_mul u_rot_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stg   (stg_b),
        .o_stg   (stg_c)
    );

    qmr_rot_sum u_rot_sum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stg    (stg_c),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

// File: design/qmr_checker.sv
// Port-level checker of the quaternion unit and its bind to the top level.
module qmr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input qmr_pkg::t_in_item  i_item,
    input logic               o_busy,
    input logic               o_valid,
    input qmr_pkg::t_out_item o_result
);

    logic take;

    assign take = i_start && !o_busy;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> ##4 o_valid)
        else $error("An accepted item gave no result four cycles later.");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(take, 4))
        else $error("A result appeared without an accepted item.");

    a_rot_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_item.func, 4) == qmr_pkg::FUNC_ROT |-> o_result.r_w == '0)
        else $error("A rotation result has a nonzero scalar part.");

    a_conj_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_item.func, 4) == qmr_pkg::FUNC_CONJ
            |-> o_result.r_w == $past(i_item.a_w, 4))
        else $error("A conjugate result does not keep the scalar part.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_busy)
        else $error("Reset did not empty the pipeline.");

endmodule

bind quaternion_multiply_rotate_unit qmr_checker u_qmr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .i_item   (i_item),
    .o_busy   (o_busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

// File: verif/quaternion_multiply_rotate_unit_tb.sv
// Self-checking testbench of the quaternion multiply, rotate and conjugate unit.
module quaternion_multiply_rotate_unit_tb;
    import qmr_pkg::*;

    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int N_RANDOM    = 1300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;
    localparam int MAX_REPORTS = 10;
    localparam int ONE_Q14     = 1 << FRAC_W;
    localparam int DMAX        = (1 << (DATA_W - 1)) - 1;
    localparam int DMIN        = -(1 << (DATA_W - 1));

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    t_in_item           i_item = '0;
    logic               o_busy;
    logic               o_valid;
    t_out_item          o_result;

    t_in_item  operand_queue[$];
    t_out_item pending_quats[$];
    bit        in_flight = 1'b0;
    int        issued_count = 0;
    int        n_directed = 0;
    int        phase1_end = 0;
    int        phase2_end = 0;
    int        cycle_count = 0;
    int        mismatch_count = 0;
    int        checked_count = 0;
    int        sat_count = 0;
    int        func_count[4] = '{0, 0, 0, 0};

    quaternion_multiply_rotate_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint round_q(input longint s);
        return (s + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    endfunction

    function automatic t_sat clip_q(input longint x);
        t_sat r;
        r.clip = 1'b0;
        r.val  = t_data'(x);
        if (x > longint'(DMAX)) begin
            r.val  = t_data'(DMAX);
            r.clip = 1'b1;
        end else if (x < longint'(DMIN)) begin
            r.val  = t_data'(DMIN);
            r.clip = 1'b1;
        end
        return r;
    endfunction

    function automatic t_out_item quat_op_result(input t_in_item it);
        longint    a[4];
        longint    b[4];
        longint    c[3];
        longint    res[4];
        longint    s;
        t_sat      q;
        t_data     outv[4];
        t_out_item r;
        logic      clipped;
        int        j;
        int        k;
        a[0] = longint'($signed(it.a_w));
        a[1] = longint'($signed(it.a_x));
        a[2] = longint'($signed(it.a_y));
        a[3] = longint'($signed(it.a_z));
        b[0] = longint'($signed(it.b_w));
        b[1] = longint'($signed(it.b_x));
        b[2] = longint'($signed(it.b_y));
        b[3] = longint'($signed(it.b_z));
        res = '{0, 0, 0, 0};
        clipped = 1'b0;
        case (it.func)
            FUNC_PROD: begin
                res[0] = round_q(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]);
                res[1] = round_q(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]);
                res[2] = round_q(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1]);
                res[3] = round_q(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0]);
            end
            FUNC_ROT: begin
                for (int i = 0; i < 3; i++) begin
                    j = (i + 1) % 3;
                    k = (i + 2) % 3;
                    q = clip_q(round_q(a[j+1]*b[k+1] - a[k+1]*b[j+1]));
                    c[i] = longint'(q.val);
                    clipped |= q.clip;
                end
                for (int i = 0; i < 3; i++) begin
                    j = (i + 1) % 3;
                    k = (i + 2) % 3;
                    s = 2*a[0]*c[i] + 2*a[j+1]*c[k] - 2*a[k+1]*c[j];
                    res[i+1] = b[i+1] + round_q(s);
                end
            end
            FUNC_CONJ: begin
                res[0] = a[0];
                res[1] = -a[1];
                res[2] = -a[2];
                res[3] = -a[3];
            end
            default: begin
            end
        endcase
        for (int i = 0; i < 4; i++) begin
            q = clip_q(res[i]);
            outv[i] = q.val;
            clipped |= q.clip;
        end
        r.r_w = outv[0];
        r.r_x = outv[1];
        r.r_y = outv[2];
        r.r_z = outv[3];
        r.saturated = clipped;
        return r;
    endfunction

    task automatic push_item(input logic [1:0] f, input int aw, input int ax, input int ay,
                             input int az, input int bw, input int bx, input int by,
                             input int bz);
        t_in_item it;
        it.func = f;
        it.a_w = t_data'(aw);
        it.a_x = t_data'(ax);
        it.a_y = t_data'(ay);
        it.a_z = t_data'(az);
        it.b_w = t_data'(bw);
        it.b_x = t_data'(bx);
        it.b_y = t_data'(by);
        it.b_z = t_data'(bz);
        operand_queue.push_back(it);
    endtask

    function automatic int rand_q14();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) begin
            case ($urandom_range(4))
                0: return DMAX;
                1: return DMIN;
                2: return 0;
                3: return ONE_Q14;
                default: return -ONE_Q14;
            endcase
        end else if (pick < 5) begin
            return $signed(16'($urandom));
        end
        return int'($urandom_range(2 * ONE_Q14)) - ONE_Q14;
    endfunction

    function automatic logic [1:0] rand_func();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) return FUNC_PROD;
        if (pick < 80) return FUNC_ROT;
        if (pick < 95) return FUNC_CONJ;
        return FUNC_NONE;
    endfunction

    function automatic bit drain_hold();
        return (issued_count == n_directed || issued_count == phase1_end ||
                issued_count == phase2_end) && pending_quats.size() != 0;
    endfunction

    function automatic int sender_idle_pct();
        if (issued_count < phase1_end) return 33;
        if (issued_count < phase2_end) return 61;
        return 0;
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!in_flight) begin
            if (operand_queue.size() != 0 && !drain_hold() &&
                int'($urandom_range(99)) >= sender_idle_pct()) begin
                i_item <= operand_queue.pop_front();
                i_start <= 1'b1;
                in_flight = 1'b1;
                issued_count++;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && i_start && !o_busy) begin
            exp_r = quat_op_result(i_item);
            pending_quats.push_back(exp_r);
            func_count[i_item.func]++;
            if (exp_r.saturated) sat_count++;
            in_flight = 1'b0;
        end
        if (i_rst_n && o_valid) begin
            if (pending_quats.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("tb: unexpected result w=%0d x=%0d y=%0d z=%0d sat=%0b",
                             o_result.r_w, o_result.r_x, o_result.r_y, o_result.r_z,
                             o_result.saturated);
            end else begin
                exp_r = pending_quats.pop_front();
                checked_count++;
                if (o_result.r_w !== exp_r.r_w || o_result.r_x !== exp_r.r_x ||
                    o_result.r_y !== exp_r.r_y || o_result.r_z !== exp_r.r_z ||
                    o_result.saturated !== exp_r.saturated) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("tb: mismatch on result %0d", checked_count);
                        $display("  expected w=%0d x=%0d y=%0d z=%0d sat=%0b",
                                 exp_r.r_w, exp_r.r_x, exp_r.r_y, exp_r.r_z,
                                 exp_r.saturated);
                        $display("  actual   w=%0d x=%0d y=%0d z=%0d sat=%0b",
                                 o_result.r_w, o_result.r_x, o_result.r_y, o_result.r_z,
                                 o_result.saturated);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int total;
        push_item(FUNC_PROD, ONE_Q14, 0, 0, 0, ONE_Q14, 0, 0, 0);
        push_item(FUNC_PROD, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX);
        push_item(FUNC_PROD, DMIN, DMIN, DMIN, DMIN, DMIN, DMIN, DMIN, DMIN);
        push_item(FUNC_PROD, DMAX, DMAX, DMAX, DMAX, DMIN, DMIN, DMIN, DMIN);
        push_item(FUNC_PROD, 1, 0, 0, 0, ONE_Q14 / 2, 0, 0, 0);
        push_item(FUNC_PROD, -1, 0, 0, 0, ONE_Q14 / 2, 0, 0, 0);
        push_item(FUNC_PROD, 0, ONE_Q14, 0, 0, 0, 0, ONE_Q14, 0);
        push_item(FUNC_PROD, 0, 0, 0, 0, DMAX, DMIN, DMAX, DMIN);
        push_item(FUNC_ROT, ONE_Q14, 0, 0, 0, -1, ONE_Q14, -ONE_Q14, ONE_Q14 / 2);
        push_item(FUNC_ROT, 11585, 0, 0, 11585, 0, ONE_Q14, 0, 0);
        push_item(FUNC_ROT, DMIN, DMIN, DMIN, DMIN, DMIN, DMIN, DMIN, DMIN);
        push_item(FUNC_ROT, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX);
        push_item(FUNC_ROT, 0, DMAX, DMIN, DMAX, DMAX, DMIN, DMAX, DMIN);
        push_item(FUNC_CONJ, ONE_Q14, 100, -200, 300, 1234, -5, 77, DMIN);
        push_item(FUNC_CONJ, DMIN, DMIN, DMIN, DMIN, 0, 0, 0, 0);
        push_item(FUNC_CONJ, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX, DMAX);
        push_item(FUNC_NONE, -1, -1, -1, -1, -1, -1, -1, -1);
        push_item(FUNC_NONE, DMAX, DMIN, DMAX, DMIN, DMAX, DMIN, DMAX, DMIN);
        n_directed = operand_queue.size();
        for (int n = 0; n < N_RANDOM; n++)
            push_item(rand_func(), rand_q14(), rand_q14(), rand_q14(), rand_q14(),
                      rand_q14(), rand_q14(), rand_q14(), rand_q14());
        total = operand_queue.size();
        phase1_end = total / 3;
        phase2_end = 2 * total / 3;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (operand_queue.size() != 0 || in_flight || pending_quats.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("tb: %0d results checked: %0d product, %0d rotate, %0d conjugate, %0d unused",
                 checked_count, func_count[FUNC_PROD], func_count[FUNC_ROT],
                 func_count[FUNC_CONJ], func_count[FUNC_NONE]);
        $display("tb: %0d results clipped, %0d mismatches", sat_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
design/qmr_pkg.sv
design/qmr_mul_array.sv
design/qmr_dot_round.sv
design/qmr_rot_mul.sv
design/qmr_rot_sum.sv
design/quaternion_multiply_rotate_unit.sv
design/qmr_checker.sv
verif/quaternion_multiply_rotate_unit_tb.sv
